/* rtl/cpsb_pkg.sv */
// Shared types and constants for the column-post sprite blitter.
// Used by cpsb_decode, cpsb_addr and column_post_sprite_blitter; no dependencies.
`default_nettype none
package cpsb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 200;
  localparam int NUM_SCREENS_DEF   = 5;

  localparam int ADDR_W = 19;
  localparam int BOX_W  = 11;
  localparam int POS_W  = 10;   // screen column / row, up to 1024 positions
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  localparam logic [7:0] END_MARK = 8'hff;

  localparam logic signed [BOX_W-1:0] BOX_MAX = {1'b0, {(BOX_W-1){1'b1}}};
  localparam logic signed [BOX_W-1:0] BOX_MIN = {1'b1, {(BOX_W-1){1'b0}}};

  // operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // draw modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_WINDOW = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SELECT = 3'd7;

  typedef struct packed {
    logic [8:0] origin_x;
    logic [7:0] origin_y;
    logic [8:0] patch_width;
    logic [7:0] patch_height;
    logic [1:0] draw_mode;
    logic [8:0] window_first;
    logic [8:0] window_width;
    logic [2:0] screen_select;
  } cpsb_cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [8:0] source_column;
    logic       column_first;
    logic [7:0] stream_byte;
  } cpsb_in_t;

  typedef struct packed {
    logic signed [BOX_W-1:0] left;
    logic signed [BOX_W-1:0] right;
    logic signed [BOX_W-1:0] bottom;
    logic signed [BOX_W-1:0] top;
  } cpsb_box_t;

  // decoded pixel write, before the address is formed
  typedef struct packed {
    logic             write_valid;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [2:0]       screen;
    logic [7:0]       pixel;
    logic             column_done;
    cpsb_box_t        box;
  } cpsb_req_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_pixel;
    logic              column_done;
    cpsb_box_t         box;
  } cpsb_out_t;

endpackage
`default_nettype wire

/* rtl/cpsb_decode.sv */
// Post decoder and dirty-box tracker: one item per cycle into a request register while load is high.
// Depends on cpsb_pkg.
`default_nettype none
module cpsb_decode #(
  parameter int SCREEN_WIDTH  = cpsb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cpsb_pkg::SCREEN_HEIGHT_DEF,
  parameter int NUM_SCREENS   = cpsb_pkg::NUM_SCREENS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,      // take the input stage into the request stage
  input  wire logic                in_valid,
  input  wire cpsb_pkg::cpsb_in_t  in_item,
  input  wire cpsb_pkg::cpsb_cfg_t cfg,
  output logic                     req_valid,
  output cpsb_pkg::cpsb_req_t      req
);
  import cpsb_pkg::*;

  typedef enum logic [2:0] {
    PH_TOP, PH_LEN, PH_PAD1, PH_PIX, PH_PAD2
  } phase_t;

  typedef struct packed {
    logic signed [BOX_W-1:0] lo;
    logic signed [BOX_W-1:0] hi;
  } span_t;

  // else-if growth: below low lowers it, otherwise above high raises it
  function automatic span_t grow(span_t s, logic signed [BOX_W-1:0] v);
    span_t r;
    r = s;
    if (v < s.lo) begin
      r.lo = v;
    end else if (v > s.hi) begin
      r.hi = v;
    end
    return r;
  endfunction

  phase_t    phase_r, phase_nxt;
  logic [8:0] post_row_r, post_row_nxt;
  logic [7:0] pixels_left_r, pixels_left_nxt;
  cpsb_box_t box_r, box_nxt;
  logic      req_valid_r;
  cpsb_req_t req_r, req_nxt;

  logic [8:0]       width_sel;
  logic [POS_W-1:0] col;
  logic             col_ok;
  logic [POS_W-1:0] row;
  logic signed [BOX_W-1:0] x1, y1, x2, y2;
  span_t sx, sy;
  phase_t phase_cur;
  logic [7:0] left_dec;

  always_comb begin
    width_sel = (cfg.draw_mode == MODE_WINDOW) ? cfg.window_width : cfg.patch_width;
    x1 = $signed({2'b00, cfg.origin_x});
    y1 = $signed({3'b000, cfg.origin_y});
    x2 = x1 + $signed({2'b00, width_sel}) - 11'sd1;
    y2 = y1 + $signed({3'b000, cfg.patch_height}) - 11'sd1;
  end

  // destination column of the source column
  always_comb begin
    col    = '0;
    col_ok = in_item.source_column < cfg.patch_width;
    case (cfg.draw_mode)
      MODE_MIRROR: begin
        col = {1'b0, cfg.origin_x}
            + {1'b0, 9'(cfg.patch_width - 9'd1 - in_item.source_column)};
      end
      MODE_WINDOW: begin
        if (in_item.source_column < cfg.window_first ||
            {1'b0, in_item.source_column} >=
            {1'b0, cfg.window_first} + {1'b0, cfg.window_width}) begin
          col_ok = 1'b0;
        end
        col = {1'b0, cfg.origin_x}
            + {1'b0, 9'(in_item.source_column - cfg.window_first)};
      end
      default: begin
        col = {1'b0, cfg.origin_x} + {1'b0, in_item.source_column};
      end
    endcase
    row = {2'b00, cfg.origin_y} + {1'b0, post_row_r};
  end

  always_comb begin
    phase_nxt       = phase_r;
    post_row_nxt    = post_row_r;
    pixels_left_nxt = pixels_left_r;
    box_nxt         = box_r;
    sx              = '0;
    sy              = '0;
    phase_cur       = phase_r;
    left_dec        = pixels_left_r - 8'd1;
    req_nxt             = '0;
    req_nxt.column      = col;
    req_nxt.row         = row;
    req_nxt.screen      = cfg.screen_select;

    case (in_item.operation)
      OP_BEGIN: begin
        phase_nxt       = PH_TOP;
        post_row_nxt    = '0;
        pixels_left_nxt = '0;
        if (cfg.screen_select == 3'd0) begin
          sx = grow(grow('{lo: box_r.left, hi: box_r.right}, x1), x2);
          sy = grow(grow('{lo: box_r.bottom, hi: box_r.top}, y1), y2);
          box_nxt.left   = sx.lo;
          box_nxt.right  = sx.hi;
          box_nxt.bottom = sy.lo;
          box_nxt.top    = sy.hi;
        end
      end
      OP_CLEAR: begin
        box_nxt = '{left: BOX_MAX, right: BOX_MIN, bottom: BOX_MAX, top: BOX_MIN};
      end
      OP_BYTE: begin
        if (in_item.column_first) begin
          phase_cur = PH_TOP;
        end
        case (phase_cur)
          PH_TOP: begin
            if (in_item.stream_byte == END_MARK) begin
              req_nxt.column_done = 1'b1;
              phase_nxt           = PH_TOP;
            end else begin
              post_row_nxt = {1'b0, in_item.stream_byte};
              phase_nxt    = PH_LEN;
            end
          end
          PH_LEN: begin
            pixels_left_nxt = in_item.stream_byte;
            phase_nxt       = PH_PAD1;
          end
          PH_PAD1: begin
            phase_nxt = (pixels_left_r != 8'd0) ? PH_PIX : PH_PAD2;
          end
          PH_PIX: begin
            if (col_ok && {1'b0, col} < 11'(SCREEN_WIDTH) &&
                {1'b0, row} < 11'(SCREEN_HEIGHT) &&
                {1'b0, cfg.screen_select} < 4'(NUM_SCREENS)) begin
              req_nxt.write_valid = 1'b1;
              req_nxt.pixel       = in_item.stream_byte;
            end
            post_row_nxt    = post_row_r + 9'd1;
            pixels_left_nxt = left_dec;
            phase_nxt       = (left_dec == 8'd0) ? PH_PAD2 : PH_PIX;
          end
          default: begin
            phase_nxt = PH_TOP;
          end
        endcase
      end
      default: begin
      end
    endcase
    req_nxt.box = box_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TOP;
      post_row_r    <= '0;
      pixels_left_r <= '0;
      box_r         <= '{left: BOX_MAX, right: BOX_MIN, bottom: BOX_MAX, top: BOX_MIN};
      req_valid_r   <= 1'b0;
    end else if (load) begin
      req_valid_r <= in_valid;
      if (in_valid) begin
        phase_r       <= phase_nxt;
        post_row_r    <= post_row_nxt;
        pixels_left_r <= pixels_left_nxt;
        box_r         <= box_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      req_r <= req_nxt;
    end
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule
`default_nettype wire

/* rtl/cpsb_addr.sv */
// Framebuffer address former and result register.
// Depends on cpsb_pkg.
`default_nettype none
module cpsb_addr #(
  parameter int SCREEN_WIDTH  = cpsb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cpsb_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic                req_valid,
  input  wire cpsb_pkg::cpsb_req_t req,
  output logic                     out_valid,
  output cpsb_pkg::cpsb_out_t      out_item
);
  import cpsb_pkg::*;

  // address wraps at 2**ADDR_W, so every term is kept modulo that
  localparam logic [ADDR_W-1:0] ROW_PITCH   = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] SCREEN_SIZE = ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT);

  logic              out_valid_r;
  cpsb_out_t         out_r, out_nxt;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    addr = ADDR_W'(ADDR_W'(req.screen) * SCREEN_SIZE)
         + ADDR_W'(ADDR_W'(req.row) * ROW_PITCH)
         + ADDR_W'(req.column);
    out_nxt.write_valid   = req.write_valid;
    out_nxt.write_address = req.write_valid ? addr : '0;
    out_nxt.write_pixel   = req.pixel;
    out_nxt.column_done   = req.column_done;
    out_nxt.box           = req.box;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* rtl/column_post_sprite_blitter.sv */
// Column-post sprite blitter: an accepted item passes through the input register,
// then the decode register, then the address/result register.
// Throughput: one item per cycle while the output is not stalled; every item yields one result item.
// Stages advance together when the result slot is free or being taken.
// Reset (rst_n low, synchronous) empties the pipeline, restarts the post decoder,
// returns the dirty box to its empty extremes and the registers to their defaults.
`default_nettype none
module column_post_sprite_blitter #(
  parameter int SCREEN_WIDTH  = cpsb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = cpsb_pkg::SCREEN_HEIGHT_DEF,
  parameter int NUM_SCREENS   = cpsb_pkg::NUM_SCREENS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [cpsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cpsb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [8:0] source_column, [9] column_first, [17:10] stream_byte, [23:18] zero
  input  wire logic [cpsb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  wire logic [1:0]                          in_tuser,
  // result items
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [18:0] write_address, [26:19] write_pixel, [27] column_done,
  // [38:28] box_left, [49:39] box_right, [60:50] box_bottom, [71:61] box_top
  output logic [cpsb_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // [0] write_valid
  output logic                                     out_tuser
);
  import cpsb_pkg::*;

  cpsb_cfg_t cfg_r;

  // input stage
  logic      in_valid_r;
  cpsb_in_t  in_r;

  // pipeline moves
  logic      adv_out, adv_req, adv_in;
  logic      req_valid;
  cpsb_req_t req;
  logic      res_valid;
  cpsb_out_t res;

  // Advance from the output back: a stage loads when the one after it moves or it is empty.
  assign adv_out   = !res_valid || out_tready;
  assign adv_req   = !req_valid || adv_out;
  assign adv_in    = !in_valid_r || adv_req;
  assign in_tready = adv_in;

  // Config registers; the user makes writes only while the block is idle; unenforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x: 9'd0, origin_y: 8'd0, patch_width: 9'd1, patch_height: 8'd1,
                 draw_mode: MODE_NORMAL, window_first: 9'd0, window_width: 9'd1,
                 screen_select: 3'd0};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata;
        REG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata[7:0];
        REG_PATCH_WIDTH:   cfg_r.patch_width   <= cfg_wdata;
        REG_PATCH_HEIGHT:  cfg_r.patch_height  <= cfg_wdata[7:0];
        REG_DRAW_MODE:     cfg_r.draw_mode     <= cfg_wdata[1:0];
        REG_WINDOW_FIRST:  cfg_r.window_first  <= cfg_wdata;
        REG_WINDOW_WIDTH:  cfg_r.window_width  <= cfg_wdata;
        REG_SCREEN_SELECT: cfg_r.screen_select <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted item in the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv_in) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_tvalid) begin
      in_r.operation     <= in_tuser;
      in_r.source_column <= in_tdata[8:0];
      in_r.column_first  <= in_tdata[9];
      in_r.stream_byte   <= in_tdata[17:10];
    end
  end

  // Decode the post byte, update decoder state and dirty box.
  cpsb_decode #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .NUM_SCREENS   (NUM_SCREENS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv_req),
    .in_valid  (in_valid_r),
    .in_item   (in_r),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req       (req)
  );

  // Form the framebuffer address and hold the result until taken.
  cpsb_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv_out),
    .req_valid (req_valid),
    .req       (req),
    .out_valid (res_valid),
    .out_item  (res)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.write_valid;
  assign out_tdata  = {res.box.top, res.box.bottom, res.box.right, res.box.left,
                       res.column_done, res.write_pixel, res.write_address};

endmodule
`default_nettype wire
